// File: hdl/lobm_pkg.sv
// lobm_pkg: shared types, codes and sizes of the order book matcher
// no dependencies; compiled first
package lobm_pkg;

  localparam int unsigned BOOK_DEPTH = 64;
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned QTY_W      = 24;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [OP_W-1:0] OP_LIMIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_MARKET = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
  // unused code, handled as a limit order
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

  localparam logic SIDE_BUY = 1'b0;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PARTIAL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FILLED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BOOK_FULL = 3'd5;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   rem;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_SUB
  } cell_cmd_e;

  // broadcast to every cell of one book
  typedef struct packed {
    cell_cmd_e          cmd;
    logic               pop;
    logic               desc;
    logic [PRICE_W-1:0] key_price;
    logic [ID_W-1:0]    key_id;
    entry_t             new_entry;
    logic [QTY_W-1:0]   sub_qty;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_CANCEL_BID,
    S_CANCEL_ASK,
    S_INSERT,
    S_FINISH
  } state_e;

endpackage

// File: hdl/lobm_if.sv
// lobm_in_if / lobm_out_if: valid-ready channels of the order book matcher
// depends on lobm_pkg
interface lobm_in_if;
  logic                          valid;
  logic                          ready;
  logic [lobm_pkg::OP_W-1:0]     operation;
  logic [lobm_pkg::ID_W-1:0]     ord_ref;
  logic                          side;
  logic [lobm_pkg::PRICE_W-1:0]  limit_price;
  logic [lobm_pkg::QTY_W-1:0]    quantity;
  modport source (output valid, operation, ord_ref, side, limit_price, quantity,
                  input ready);
  modport sink (input valid, operation, ord_ref, side, limit_price, quantity,
                output ready);
endinterface

interface lobm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lobm_pkg::ID_W-1:0]     ack_ref;
  logic [lobm_pkg::STATUS_W-1:0] status;
  logic [lobm_pkg::PRICE_W-1:0]  last_px;
  logic [lobm_pkg::QTY_W-1:0]    done_qty;
  modport source (output valid, ack_ref, status, last_px, done_qty,
                  input ready);
  modport sink (input valid, ack_ref, status, last_px, done_qty,
                output ready);
endinterface

// File: hdl/limit_order_book_matcher.sv
// limit_order_book_matcher: price-time priority matcher over a bid and an ask book
// depends on lobm_pkg, lobm_if, lobm_book, lobm_cell
//
// Each book is a row of BookDepth cells kept sorted (bids highest first, asks
// lowest first, arrival order within a price); every cell compares its own
// order against a broadcast key and shifts with its neighbors.
// One item is in work at a time. A limit or market order is taken in, then
// gets a match step for each resting order it touches (fully consumed or
// reduced) plus a closing match step, an insert step to rest a limit
// remainder, and a finish step that loads the result register. A cancel
// searches the bids, then the asks when not found among the bids, and then
// finishes. The result register is loaded only once the previous result has
// been taken.
// Status: 0 accepted, 1 partial, 2 filled, 3 rejected, 4 cancelled,
// 5 book full (limit remainder dropped, fills still reported).
module limit_order_book_matcher #(
  parameter int unsigned BookDepth = lobm_pkg::BOOK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lobm_in_if.sink    in_if,
  lobm_out_if.source out_if
);
  import lobm_pkg::*;

  localparam int unsigned CntW = $clog2(BookDepth + 1);

  state_e state_q, state_d;

  // item under work
  logic [OP_W-1:0]     op_q;
  logic [ID_W-1:0]     id_q;
  logic                buy_q;
  logic [PRICE_W-1:0]  price_q;
  logic [QTY_W-1:0]    qty_q, qty_d;
  logic [QTY_W-1:0]    filled_q, filled_d;
  logic [PRICE_W-1:0]  fp_q, fp_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // result register
  logic                out_valid_q;
  logic [ID_W-1:0]     out_id_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PRICE_W-1:0]  out_fp_q;
  logic [QTY_W-1:0]    out_qty_q;
  logic                out_load;

  cell_ctl_t       bid_ctl, ask_ctl;
  logic [CntW-1:0] bid_cnt, ask_cnt;
  entry_t          bid_front, ask_front;
  logic            bid_hit, ask_hit;

  // match-step helpers, opposite book seen from the incoming order
  entry_t          opp_front;
  logic [CntW-1:0] opp_cnt, own_cnt;
  logic            market, crosses;
  logic [QTY_W-1:0] take;
  cell_ctl_t       opp_ctl, own_ctl;

  lobm_book #(.BookDepth(BookDepth)) u_bids (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (bid_ctl),
    .cnt_o (bid_cnt), .front_o (bid_front), .hit_o (bid_hit)
  );

  lobm_book #(.BookDepth(BookDepth)) u_asks (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (ask_ctl),
    .cnt_o (ask_cnt), .front_o (ask_front), .hit_o (ask_hit)
  );

  assign in_if.ready = (state_q == S_IDLE);

  always_comb begin
    opp_front = (buy_q == SIDE_BUY) ? ask_front : bid_front;
    opp_cnt   = (buy_q == SIDE_BUY) ? ask_cnt : bid_cnt;
    own_cnt   = (buy_q == SIDE_BUY) ? bid_cnt : ask_cnt;
    market    = (op_q == OP_MARKET);
    // buyer needs ask <= limit, seller needs bid >= limit
    crosses   = market || ((buy_q == SIDE_BUY) ? (opp_front.price <= price_q)
                                               : (opp_front.price >= price_q));
    take      = (qty_q < opp_front.rem) ? qty_q : opp_front.rem;

    state_d  = state_q;
    qty_d    = qty_q;
    filled_d = filled_q;
    fp_d     = fp_q;
    status_d = status_q;
    out_load = 1'b0;

    opp_ctl           = '0;
    opp_ctl.cmd       = CMD_NONE;
    opp_ctl.key_id    = id_q;
    opp_ctl.key_price = price_q;
    own_ctl           = opp_ctl;
    own_ctl.desc      = (buy_q == SIDE_BUY);
    own_ctl.new_entry = '{price: price_q, rem: qty_q, id: id_q};
    bid_ctl           = opp_ctl;
    ask_ctl           = opp_ctl;

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          qty_d    = in_if.quantity;
          filled_d = '0;
          fp_d     = '0;
          state_d  = (in_if.operation == OP_CANCEL) ? S_CANCEL_BID : S_MATCH;
        end
      end
      S_MATCH: begin
        if (qty_q != '0 && opp_cnt != '0 && crosses) begin
          fp_d     = opp_front.price;
          filled_d = filled_q + take;
          qty_d    = qty_q - take;
          if (opp_front.rem <= qty_q) begin
            // front order used up: pop it off the row
            opp_ctl.cmd = CMD_REMOVE;
            opp_ctl.pop = 1'b1;
          end else begin
            opp_ctl.cmd     = CMD_SUB;
            opp_ctl.sub_qty = take;
          end
        end else if (market) begin
          status_d = (filled_q != '0) ? ST_FILLED : ST_REJECTED;
          state_d  = S_FINISH;
        end else if (qty_q != '0) begin
          state_d = S_INSERT;
        end else begin
          status_d = (filled_q != '0) ? ST_FILLED : ST_ACCEPTED;
          state_d  = S_FINISH;
        end
      end
      S_INSERT: begin
        if (own_cnt == CntW'(BookDepth)) begin
          status_d = ST_BOOK_FULL;
        end else begin
          own_ctl.cmd = CMD_INSERT;
          status_d    = (filled_q != '0) ? ST_PARTIAL : ST_ACCEPTED;
        end
        state_d = S_FINISH;
      end
      S_CANCEL_BID: begin
        bid_ctl.cmd = CMD_REMOVE;
        if (bid_hit) begin
          status_d = ST_CANCELLED;
          state_d  = S_FINISH;
        end else begin
          state_d = S_CANCEL_ASK;
        end
      end
      S_CANCEL_ASK: begin
        ask_ctl.cmd = CMD_REMOVE;
        status_d    = ask_hit ? ST_CANCELLED : ST_REJECTED;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // route the side-relative commands onto the two books
    if (state_q == S_MATCH) begin
      if (buy_q == SIDE_BUY) ask_ctl = opp_ctl;
      else                   bid_ctl = opp_ctl;
    end else if (state_q == S_INSERT) begin
      if (buy_q == SIDE_BUY) bid_ctl = own_ctl;
      else                   ask_ctl = own_ctl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) begin
      op_q    <= in_if.operation;
      id_q    <= in_if.ord_ref;
      buy_q   <= in_if.side;
      price_q <= in_if.limit_price;
    end
    qty_q    <= qty_d;
    filled_q <= filled_d;
    fp_q     <= fp_d;
    status_q <= status_d;
    if (out_load) begin
      out_id_q     <= id_q;
      out_status_q <= status_d;
      out_fp_q     <= fp_q;
      out_qty_q    <= filled_q;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.ack_ref  = out_id_q;
  assign out_if.status   = out_status_q;
  assign out_if.last_px  = out_fp_q;
  assign out_if.done_qty = out_qty_q;

`ifndef SYNTH
  // books never hold more than their depth
  a_bid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bid_cnt <= CntW'(BookDepth)) else $error("bid count beyond depth");
  a_ask_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ask_cnt <= CntW'(BookDepth)) else $error("ask count beyond depth");
  // the bid count moves by at most one order per cycle
  a_bid_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_cnt != $past(bid_cnt)) |->
      (bid_cnt == $past(bid_cnt) + CntW'(1) || bid_cnt == $past(bid_cnt) - CntW'(1)))
    else $error("bid count jumped");
  // a result appears only after the finishing step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result without finish");
  // an item is taken only while no other is in work
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> (state_q == S_MATCH || state_q == S_CANCEL_BID))
    else $error("item accepted outside idle");
`endif

endmodule

// File: hdl/lobm_cell.sv
// lobm_cell: one resting order slot of a book, shifts left or right with its neighbors
// depends on lobm_pkg
module lobm_cell #(
  parameter int unsigned BookDepth = lobm_pkg::BOOK_DEPTH,
  parameter int unsigned Idx       = 0
) (
  input  logic                               clk_i,
  input  logic [$clog2(BookDepth+1)-1:0]     cnt_i,
  input  lobm_pkg::cell_ctl_t                ctl_i,
  input  lobm_pkg::entry_t                   left_i,
  input  logic                               left_keep_i,
  input  logic                               seen_i,
  input  lobm_pkg::entry_t                   right_i,
  output lobm_pkg::entry_t                   entry_o,
  output logic                               keep_o,
  output logic                               seen_o
);
  import lobm_pkg::*;

  localparam int unsigned CntW = $clog2(BookDepth + 1);
  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  entry_t entry_q, entry_d;
  logic   valid, hit;

  always_comb begin
    valid  = IdxC < cnt_i;
    // stays in place on insert: ahead of or equal to the new price
    keep_o = valid && (ctl_i.desc ? (entry_q.price >= ctl_i.key_price)
                                  : (entry_q.price <= ctl_i.key_price));
    hit    = valid && (entry_q.id == ctl_i.key_id);
    seen_o = seen_i | hit;
    entry_d = entry_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (!keep_o) entry_d = left_keep_i ? ctl_i.new_entry : left_i;
      end
      CMD_REMOVE: begin
        if (seen_o) entry_d = right_i;
      end
      CMD_SUB: begin
        if (Idx == 0) entry_d.rem = entry_q.rem - ctl_i.sub_qty;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/lobm_book.sv
// lobm_book: one side of the book as a row of cells plus its order count
// depends on lobm_pkg, lobm_cell
module lobm_book #(
  parameter int unsigned BookDepth = lobm_pkg::BOOK_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lobm_pkg::cell_ctl_t            ctl_i,
  output logic [$clog2(BookDepth+1)-1:0] cnt_o,
  output lobm_pkg::entry_t               front_o,
  output logic                           hit_o
);
  import lobm_pkg::*;

  localparam int unsigned CntW = $clog2(BookDepth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  entry_t          entry_w [BookDepth];
  logic            keep_w  [BookDepth];
  logic            seen_w  [BookDepth+1];

  assign seen_w[0] = ctl_i.pop;

  for (genvar i = 0; i < BookDepth; i++) begin : g_cell
    entry_t left_w, right_w;
    logic   lkeep_w;
    if (i == 0) begin : g_first
      assign left_w  = entry_w[0];
      assign lkeep_w = 1'b1;
    end else begin : g_mid
      assign left_w  = entry_w[i-1];
      assign lkeep_w = keep_w[i-1];
    end
    if (i == BookDepth - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_body
      assign right_w = entry_w[i+1];
    end
    lobm_cell #(.BookDepth(BookDepth), .Idx(i)) u_cell (
      .clk_i       (clk_i),
      .cnt_i       (cnt_q),
      .ctl_i       (ctl_i),
      .left_i      (left_w),
      .left_keep_i (lkeep_w),
      .seen_i      (seen_w[i]),
      .right_i     (right_w),
      .entry_o     (entry_w[i]),
      .keep_o      (keep_w[i]),
      .seen_o      (seen_w[i+1])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    case (ctl_i.cmd)
      CMD_INSERT: cnt_d = cnt_q + CntW'(1);
      CMD_REMOVE: if (seen_w[BookDepth]) cnt_d = cnt_q - CntW'(1);
      default:    cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o   = cnt_q;
  assign front_o = entry_w[0];
  assign hit_o   = seen_w[BookDepth];

endmodule
